>>> hw/rtl/smf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and constants for the searchable message fifo.
// ----------------------------------------------------------------------------
package smf_pkg;

  // fixed field widths of the channels
  localparam int OPCODE_W = 2;
  localparam int VALUE_W  = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // default sizing
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 16;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_ENQ   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DEQ   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SRCH  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic enq;        // write key into the cell at the tail
    logic deq;        // every cell takes its right neighbor's entry
    logic srch_load;  // capture the local compare result
    logic srch_step;  // fold in the right neighbor's hit flag
  } cell_ctl_t;

endpackage : smf_pkg
`default_nettype wire

>>> hw/rtl/smf_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smf_cell
// One slot of the queue chain: holds one entry, shifts toward the head on
// dequeue and passes its search hit flag toward the head one step a cycle.
// ----------------------------------------------------------------------------
module smf_cell #(
  parameter int DATA_WIDTH = 16,
  parameter int CNT_W      = 5,
  parameter int IDX        = 0
) (
  input  wire                     clk,
  input  wire smf_pkg::cell_ctl_t ctl,
  input  wire [CNT_W-1:0]         count,
  input  wire [DATA_WIDTH-1:0]    key,
  input  wire [DATA_WIDTH-1:0]    right_data,
  input  wire                     right_hit,
  output logic [DATA_WIDTH-1:0]   data_r,
  output logic                    hit_r
);
  import smf_pkg::*;

  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  hit_nxt;
  logic                  held;
  logic                  is_tail;
  logic                  match;

  // slot occupancy follows from the fill count
  assign held    = count > CNT_W'(IDX);
  assign is_tail = count == CNT_W'(IDX);
  assign match   = held && (data_r == key);

  // entry update: load at the tail, shift on dequeue
  always_comb begin
    data_nxt = data_r;
    if (ctl.enq && is_tail) begin
      data_nxt = key;
    end else if (ctl.deq) begin
      data_nxt = right_data;
    end
  end

  // hit flag: local compare, then or-in from the right each step
  always_comb begin
    hit_nxt = hit_r;
    if (ctl.srch_load) begin
      hit_nxt = match;
    end else if (ctl.srch_step) begin
      hit_nxt = hit_r | right_hit;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    hit_r  <= hit_nxt;
  end

endmodule : smf_cell
`default_nettype wire

>>> hw/rtl/searchable_message_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// searchable_message_fifo
// Bounded message queue built as a chain of cells, with enqueue, dequeue,
// membership search and clear. One result per operation.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid in_ready in_opcode in_value    | to block
//  out     | out_valid out_ready out_status          | from block
//          | out_data_out out_found out_count        |
//          | out_is_empty                            |
//
// Enqueue, dequeue and clear register their result at the accepting edge.
// A search first has the cells compare, then the hit flag walks toward the
// head, and the result is registered once every cell's flag is folded in.
// Reset clears the fill count and control; entries are not cleared.
// A new item is taken while the previous result is being transferred out;
// a stalled output or a search in progress holds further input off.
// ----------------------------------------------------------------------------
module searchable_message_fifo #(
  parameter int DEPTH      = smf_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = smf_pkg::DATA_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [smf_pkg::OPCODE_W-1:0]  in_opcode,
  input  wire [smf_pkg::VALUE_W-1:0]   in_value,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [smf_pkg::STATUS_W-1:0] out_status,
  output logic [smf_pkg::VALUE_W-1:0]  out_data_out,
  output logic                         out_found,
  output logic [smf_pkg::COUNT_W-1:0]  out_count,
  output logic                         out_is_empty
);
  import smf_pkg::*;

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int STEP_W = $clog2(DEPTH);

  // controller states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_SRCH = 1'b1;

  logic                  state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [VALUE_W-1:0]    data_out_r, data_out_nxt;
  logic                  found_r, found_nxt;
  logic [COUNT_W-1:0]    count_out_r, count_out_nxt;
  logic                  empty_r, empty_nxt;

  cell_ctl_t             ctl;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [DATA_WIDTH-1:0] key;
  logic [DATA_WIDTH+VALUE_W-1:0] key_ext;
  logic [VALUE_W+DATA_WIDTH-1:0] head_ext;
  logic [COUNT_W+CNT_W-1:0]      cnt_ext;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic                  cell_hit  [DEPTH];

  assign full  = count_r == CNT_W'(DEPTH);
  assign empty = count_r == '0;

  // input value sized to the entry width
  assign key_ext = {{DATA_WIDTH{1'b0}}, in_value};
  assign key     = key_ext[DATA_WIDTH-1:0];

  // head entry sized to the result field
  assign head_ext = {{VALUE_W{1'b0}}, cell_data[0]};
  assign cnt_ext  = {{COUNT_W{1'b0}}, count_nxt};

  // input taken only when idle and the result register frees up
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // cell commands and next controller state
  always_comb begin
    ctl           = '0;
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    data_out_nxt  = data_out_r;
    found_nxt     = found_r;
    empty_nxt     = empty_r;
    if (accept) begin
      status_nxt   = STAT_DONE;
      data_out_nxt = '0;
      found_nxt    = 1'b0;
      case (in_opcode)
        OP_ENQ: begin
          out_valid_nxt = 1'b1;
          if (full) begin
            status_nxt = STAT_FULL;
          end else begin
            ctl.enq   = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_DEQ: begin
          out_valid_nxt = 1'b1;
          if (empty) begin
            status_nxt = STAT_EMPTY;
          end else begin
            ctl.deq      = 1'b1;
            data_out_nxt = head_ext[VALUE_W-1:0];
            count_nxt    = count_r - 1'b1;
          end
        end
        OP_SRCH: begin
          ctl.srch_load = 1'b1;
          step_nxt      = '0;
          state_nxt     = S_SRCH;
        end
        OP_CLEAR: begin
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
        end
        default: begin
          out_valid_nxt = 1'b1;
        end
      endcase
      empty_nxt = count_nxt == '0;
    end else if (state_r == S_SRCH) begin
      ctl.srch_step = 1'b1;
      step_nxt      = step_r + 1'b1;
      if (step_r == STEP_W'(DEPTH - 2)) begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        found_nxt     = cell_hit[0] | cell_hit[1];
      end
    end
  end

  assign count_out_nxt = cnt_ext[COUNT_W-1:0];

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result and step registers
  always_ff @(posedge clk) begin
    step_r      <= step_nxt;
    status_r    <= status_nxt;
    data_out_r  <= data_out_nxt;
    found_r     <= found_nxt;
    count_out_r <= count_out_nxt;
    empty_r     <= empty_nxt;
  end

  // chain of cells, index 0 holds the oldest entry
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] rdata;
    logic                  rhit;
    if (i == DEPTH - 1) begin : g_last
      assign rdata = '0;
      assign rhit  = 1'b0;
    end else begin : g_mid
      assign rdata = cell_data[i+1];
      assign rhit  = cell_hit[i+1];
    end
    smf_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .key        (key),
      .right_data (rdata),
      .right_hit  (rhit),
      .data_r     (cell_data[i]),
      .hit_r      (cell_hit[i])
    );
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_data_out = data_out_r;
  assign out_found    = found_r;
  assign out_count    = count_out_r;
  assign out_is_empty = empty_r;

endmodule : searchable_message_fifo
`default_nettype wire
